@@ rtl/iogbc_pkg.sv @@
package iogbc_pkg;

    localparam int COST_BITS = 20;
    localparam logic [COST_BITS-1:0] COST_MAX  = {COST_BITS{1'b1}};
    localparam logic [COST_BITS-1:0] INF_RESET = 20'd1048575;

    typedef struct packed {
        logic stale;
        logic zero_den;
    } iogbc_flags_t;

endpackage

@@ rtl/iogbc_geom.sv @@
module iogbc_geom
    import iogbc_pkg::*;
#(
    parameter int CB = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [CB-1:0]    t_left,
    input  logic signed [CB-1:0]    t_top,
    input  logic        [CB-2:0]    t_width,
    input  logic        [CB-2:0]    t_height,
    input  logic                    t_stale,
    input  logic signed [CB-1:0]    d_left,
    input  logic signed [CB-1:0]    d_top,
    input  logic        [CB-2:0]    d_width,
    input  logic        [CB-2:0]    d_height,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2*(CB-1)-1:0]     out_num,
    output logic [2*(CB-1):0]       out_den,
    output iogbc_flags_t            out_flags
);

    localparam int SW = CB - 1;
    localparam int AW = 2 * SW;
    localparam int EW = CB + 2;

    // overlap length on one axis, clamped at zero
    function automatic logic [SW-1:0] ovl(
        input logic signed [CB-1:0] a0,
        input logic        [SW-1:0] al,
        input logic signed [CB-1:0] b0,
        input logic        [SW-1:0] bl
    );
        logic signed [EW-1:0] as;
        logic signed [EW-1:0] ae;
        logic signed [EW-1:0] bs;
        logic signed [EW-1:0] be;
        logic signed [EW-1:0] lo;
        logic signed [EW-1:0] hi;
        logic signed [EW-1:0] d;
        as = EW'(a0);
        bs = EW'(b0);
        ae = as + $signed(EW'(al));
        be = bs + $signed(EW'(bl));
        lo = (as > bs) ? as : bs;
        hi = (ae < be) ? ae : be;
        d  = hi - lo;
        return d[EW-1] ? '0 : d[SW-1:0];
    endfunction

    logic          adv1;
    logic          adv2;
    logic          adv3;

    logic          v1_reg;
    logic [SW-1:0] iw_reg;
    logic [SW-1:0] ih_reg;
    logic [SW-1:0] tw_reg;
    logic [SW-1:0] th_reg;
    logic [SW-1:0] dw_reg;
    logic [SW-1:0] dh_reg;
    logic          st1_reg;
    logic [SW-1:0] iw_next;
    logic [SW-1:0] ih_next;

    logic          v2_reg;
    logic [AW-1:0] inter_reg;
    logic [AW-1:0] ta_reg;
    logic [AW-1:0] da_reg;
    logic          st2_reg;
    logic [AW-1:0] inter_next;
    logic [AW-1:0] ta_next;
    logic [AW-1:0] da_next;

    logic          v3_reg;
    logic [AW-1:0] num_reg;
    logic [AW:0]   den_reg;
    iogbc_flags_t  fl3_reg;
    logic [AW:0]   den_next;
    iogbc_flags_t  fl3_next;

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        iw_next           = ovl(t_left, t_width, d_left, d_width);
        ih_next           = ovl(t_top, t_height, d_top, d_height);
        inter_next        = AW'(iw_reg) * AW'(ih_reg);
        ta_next           = AW'(tw_reg) * AW'(th_reg);
        da_next           = AW'(dw_reg) * AW'(dh_reg);
        den_next          = (AW+1)'(ta_reg) + (AW+1)'(da_reg) - (AW+1)'(inter_reg);
        fl3_next.stale    = st2_reg;
        fl3_next.zero_den = (den_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            iw_reg  <= iw_next;
            ih_reg  <= ih_next;
            tw_reg  <= t_width;
            th_reg  <= t_height;
            dw_reg  <= d_width;
            dh_reg  <= d_height;
            st1_reg <= t_stale;
        end
        if (adv2)
        begin
            inter_reg <= inter_next;
            ta_reg    <= ta_next;
            da_reg    <= da_next;
            st2_reg   <= st1_reg;
        end
        if (adv3)
        begin
            num_reg <= inter_reg;
            den_reg <= den_next;
            fl3_reg <= fl3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_flags = fl3_reg;

endmodule

@@ rtl/iogbc_div.sv @@
module iogbc_div
    import iogbc_pkg::*;
#(
    parameter int NW = 30,
    parameter int FB = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [NW-1:0]   in_num,
    input  logic [NW:0]     in_den,
    input  iogbc_flags_t    in_flags,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [FB:0]     out_quot,
    output iogbc_flags_t    out_flags
);

    localparam int DW = NW + 1;

    logic [FB+1:0] adv;
    logic [FB:0]   v_reg;
    logic [DW-1:0] r_reg   [FB+1];
    logic [DW-1:0] den_reg [FB+1];
    logic [FB:0]   q_reg   [FB+1];
    iogbc_flags_t  fl_reg  [FB+1];
    logic [DW-1:0] r_next  [FB+1];
    logic [FB:0]   q_next  [FB+1];
    logic          eq;

    always_comb
    begin
        adv[FB+1] = out_ready;
        for (int s = FB; s >= 0; s--)
        begin
            adv[s] = !v_reg[s] || adv[s+1];
        end
    end

    assign in_ready = adv[0];

    // stage 0 takes the integer part (num <= den), then one quotient bit per stage
    always_comb
    begin
        eq        = ({1'b0, in_num} == in_den);
        r_next[0] = eq ? '0 : DW'(in_num);
        q_next[0] = (FB+1)'(eq);
        for (int s = 1; s <= FB; s++)
        begin : step
            logic [DW:0] r2;
            logic        ge;
            r2        = {r_reg[s-1], 1'b0};
            ge        = (r2 >= {1'b0, den_reg[s-1]});
            r_next[s] = ge ? DW'(r2 - {1'b0, den_reg[s-1]}) : r2[DW-1:0];
            q_next[s] = {q_reg[s-1][FB-1:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s <= FB; s++)
            begin
                if (adv[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            r_reg[0]   <= r_next[0];
            q_reg[0]   <= q_next[0];
            den_reg[0] <= in_den;
            fl_reg[0]  <= in_flags;
        end
        for (int s = 1; s <= FB; s++)
        begin
            if (adv[s])
            begin
                r_reg[s]   <= r_next[s];
                q_reg[s]   <= q_next[s];
                den_reg[s] <= den_reg[s-1];
                fl_reg[s]  <= fl_reg[s-1];
            end
        end
    end

    assign out_valid = v_reg[FB];
    assign out_quot  = q_reg[FB];
    assign out_flags = fl_reg[FB];

endmodule

@@ rtl/iou_gated_box_cost_core.sv @@
// Association cost of a track box against a detection box: 1 - IoU in unsigned fixed
// point (2^FRAC_BITS = 1.0, floor of the IoU quotient), or the programmed infinite cost
// for a stale track; disjoint boxes and a zero union give exactly 1.0. One pair is taken
// every clock while the cost side does not stall, and one cost comes out per pair, in order.
// The pipe has three geometry stages (overlap, areas, union), one stage per quotient bit in the
// pipelined divider plus its setup stage, and the output register. A stall on the cost
// side backs up stage by stage; bubbles still fill. infinite_cost is written through the
// cfg channel, always ready, and should change only while the pipe is empty.
module iou_gated_box_cost_core
    import iogbc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic signed [COORD_BITS-1:0] track_left,
    input  logic signed [COORD_BITS-1:0] track_top,
    input  logic        [COORD_BITS-2:0] track_width,
    input  logic        [COORD_BITS-2:0] track_height,
    input  logic                        track_stale,
    input  logic signed [COORD_BITS-1:0] det_left,
    input  logic signed [COORD_BITS-1:0] det_top,
    input  logic        [COORD_BITS-2:0] det_width,
    input  logic        [COORD_BITS-2:0] det_height,
    output logic                        cost_valid,
    input  logic                        cost_stall,
    output logic [COST_BITS-1:0]        match_cost,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [COST_BITS-1:0]        cfg_data
);

    localparam int NW = 2 * (COORD_BITS - 1);
    localparam logic [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;

    logic                   geo_ready;
    logic                   mid_valid;
    logic                   mid_ready;
    logic [NW-1:0]          mid_num;
    logic [NW:0]            mid_den;
    iogbc_flags_t           mid_flags;
    logic                   div_valid;
    logic                   div_ready;
    logic [FRAC_BITS:0]     div_quot;
    iogbc_flags_t           div_flags;

    logic [COST_BITS-1:0]   inf_cost_reg;
    logic                   out_v_reg;
    logic [COST_BITS-1:0]   cost_reg;
    logic [COST_BITS-1:0]   cost_next;
    logic [FRAC_BITS+1:0]   full;

    iogbc_geom #(
        .CB (COORD_BITS)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .in_ready  (geo_ready),
        .t_left    (track_left),
        .t_top     (track_top),
        .t_width   (track_width),
        .t_height  (track_height),
        .t_stale   (track_stale),
        .d_left    (det_left),
        .d_top     (det_top),
        .d_width   (det_width),
        .d_height  (det_height),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_num   (mid_num),
        .out_den   (mid_den),
        .out_flags (mid_flags)
    );

    iogbc_div #(
        .NW (NW),
        .FB (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_num    (mid_num),
        .in_den    (mid_den),
        .in_flags  (mid_flags),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_quot  (div_quot),
        .out_flags (div_flags)
    );

    assign item_stall = !geo_ready;
    assign div_ready  = !out_v_reg || !cost_stall;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        full = ONE - (FRAC_BITS+2)'(div_quot);
        if (div_flags.zero_den)
        begin
            full = ONE;
        end
        if (32'(full) > 32'(COST_MAX))
        begin
            cost_next = COST_MAX;
        end
        else
        begin
            cost_next = COST_BITS'(full);
        end
        if (div_flags.stale)
        begin
            cost_next = inf_cost_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inf_cost_reg <= INF_RESET;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                inf_cost_reg <= cfg_data;
            end
            if (div_ready)
            begin
                out_v_reg <= div_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_ready)
        begin
            cost_reg <= cost_next;
        end
    end

    assign cost_valid = out_v_reg;
    assign match_cost = cost_reg;

endmodule

@@ dv/iogbc_cost_checker.sv @@
`timescale 1ns / 100ps

module iogbc_cost_checker
    import iogbc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic                         item_stall,
    input  logic signed [COORD_BITS-1:0] track_left,
    input  logic signed [COORD_BITS-1:0] track_top,
    input  logic        [COORD_BITS-2:0] track_width,
    input  logic        [COORD_BITS-2:0] track_height,
    input  logic                         track_stale,
    input  logic signed [COORD_BITS-1:0] det_left,
    input  logic signed [COORD_BITS-1:0] det_top,
    input  logic        [COORD_BITS-2:0] det_width,
    input  logic        [COORD_BITS-2:0] det_height,
    input  logic                         cost_valid,
    input  logic                         cost_stall,
    input  logic [COST_BITS-1:0]         match_cost,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [COST_BITS-1:0]         cfg_data,
    output int                           mismatches,
    output int                           outstanding
);

    logic [COST_BITS-1:0] stale_cost;
    logic [COST_BITS-1:0] expected_costs[$];

    function automatic longint span_overlap(input longint a0, input longint alen,
                                            input longint b0, input longint blen);
        longint lo;
        longint hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    function automatic logic [COST_BITS-1:0] box_cost(
        input logic [COST_BITS-1:0]         inf_cost,
        input logic signed [COORD_BITS-1:0] tl,
        input logic signed [COORD_BITS-1:0] tt,
        input logic        [COORD_BITS-2:0] tw,
        input logic        [COORD_BITS-2:0] th,
        input logic                         stale,
        input logic signed [COORD_BITS-1:0] dl,
        input logic signed [COORD_BITS-1:0] dt,
        input logic        [COORD_BITS-2:0] dw,
        input logic        [COORD_BITS-2:0] dh
    );
        longint inter;
        longint union_area;
        longint iou_q;
        longint cost;
        if (stale)
            return inf_cost;
        inter = span_overlap(longint'(tl), longint'(tw), longint'(dl), longint'(dw))
              * span_overlap(longint'(tt), longint'(th), longint'(dt), longint'(dh));
        union_area = longint'(tw) * longint'(th) + longint'(dw) * longint'(dh) - inter;
        // zero union counts as no overlap at all
        iou_q = (union_area == 0) ? 0 : (inter <<< FRAC_BITS) / union_area;
        cost = (longint'(1) <<< FRAC_BITS) - iou_q;
        if (cost > longint'(COST_MAX))
            cost = longint'(COST_MAX);
        return cost[COST_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [COST_BITS-1:0] want;
        if (!rst_n)
        begin
            stale_cost = INF_RESET;
            expected_costs.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (cost_valid && !cost_stall)
            begin
                if (expected_costs.size() == 0)
                begin
                    $error("match_cost: transfer with none expected, expected none, actual %0d",
                           match_cost);
                    mismatches++;
                end
                else
                begin
                    want = expected_costs.pop_front();
                    if (match_cost !== want)
                    begin
                        $error("match_cost: expected %0d, actual %0d", want, match_cost);
                        mismatches++;
                    end
                end
            end
            if (item_valid && !item_stall)
                expected_costs = {expected_costs,
                                  box_cost(stale_cost, track_left, track_top,
                                           track_width, track_height, track_stale,
                                           det_left, det_top, det_width, det_height)};
            if (cfg_valid && cfg_ready)
                stale_cost = cfg_data;
            outstanding = expected_costs.size();
        end
    end

endmodule

@@ dv/iou_gated_box_cost_core_tb.sv @@
`timescale 1ns / 100ps

module iou_gated_box_cost_core_tb;
    import iogbc_pkg::*;

    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int HOLD_CYCLES = 120;
    localparam int QUIET_LIMIT = 5000;
    localparam int RANDOM_RUN  = 240;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] track_left;
        logic signed [COORD_BITS-1:0] track_top;
        logic        [COORD_BITS-2:0] track_width;
        logic        [COORD_BITS-2:0] track_height;
        logic                         track_stale;
        logic signed [COORD_BITS-1:0] det_left;
        logic signed [COORD_BITS-1:0] det_top;
        logic        [COORD_BITS-2:0] det_width;
        logic        [COORD_BITS-2:0] det_height;
    } box_pair_t;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         item_valid   = 1'b0;
    logic                         item_stall;
    logic signed [COORD_BITS-1:0] track_left   = '0;
    logic signed [COORD_BITS-1:0] track_top    = '0;
    logic        [COORD_BITS-2:0] track_width  = '0;
    logic        [COORD_BITS-2:0] track_height = '0;
    logic                         track_stale  = 1'b0;
    logic signed [COORD_BITS-1:0] det_left     = '0;
    logic signed [COORD_BITS-1:0] det_top      = '0;
    logic        [COORD_BITS-2:0] det_width    = '0;
    logic        [COORD_BITS-2:0] det_height   = '0;
    logic                         cost_valid;
    logic                         cost_stall   = 1'b0;
    logic [COST_BITS-1:0]         match_cost;
    logic                         cfg_valid    = 1'b0;
    logic                         cfg_ready;
    logic [COST_BITS-1:0]         cfg_data     = '0;

    int mismatches;
    int outstanding;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    box_pair_t directed_pairs[$];

    iou_gated_box_cost_core #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .track_left   (track_left),
        .track_top    (track_top),
        .track_width  (track_width),
        .track_height (track_height),
        .track_stale  (track_stale),
        .det_left     (det_left),
        .det_top      (det_top),
        .det_width    (det_width),
        .det_height   (det_height),
        .cost_valid   (cost_valid),
        .cost_stall   (cost_stall),
        .match_cost   (match_cost),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    iogbc_cost_checker #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) i_cost_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .track_left   (track_left),
        .track_top    (track_top),
        .track_width  (track_width),
        .track_height (track_height),
        .track_stale  (track_stale),
        .det_left     (det_left),
        .det_top      (det_top),
        .det_width    (det_width),
        .det_height   (det_height),
        .cost_valid   (cost_valid),
        .cost_stall   (cost_stall),
        .match_cost   (match_cost),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always #6 clk = ~clk;

    // cost side: long hold-off on request, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen  <= hold_req;
            hold_left  <= HOLD_CYCLES;
            cost_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left  <= hold_left - 1;
            cost_stall <= 1'b1;
        end
        else
            cost_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (cost_valid && !cost_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[iou_gated_box_cost_core] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic box_pair_t mk_pair(input int tl, input int tt, input int tw,
                                          input int th, input int stale, input int dl,
                                          input int dt, input int dw, input int dh);
        box_pair_t p;
        p.track_left   = 16'(tl);
        p.track_top    = 16'(tt);
        p.track_width  = 15'(tw);
        p.track_height = 15'(th);
        p.track_stale  = 1'(stale);
        p.det_left     = 16'(dl);
        p.det_top      = 16'(dt);
        p.det_width    = 15'(dw);
        p.det_height   = 15'(dh);
        return p;
    endfunction

    function automatic void queue_pair(input box_pair_t p);
        directed_pairs = {directed_pairs, p};
    endfunction

    function automatic logic signed [COORD_BITS-1:0] corner_coord();
        case ($urandom_range(4))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return 16'sd32766;
            3: return 16'sd32767;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic box_pair_t random_pair();
        box_pair_t p;
        int shape;
        shape = $urandom_range(99);
        p.track_left   = 16'($urandom);
        p.track_top    = 16'($urandom);
        p.track_width  = 15'($urandom_range(255));
        p.track_height = 15'($urandom_range(255));
        p.track_stale  = ($urandom_range(99) < 8);
        p.det_left     = p.track_left + 16'($urandom_range(256)) - 16'd128;
        p.det_top      = p.track_top + 16'($urandom_range(256)) - 16'd128;
        p.det_width    = 15'($urandom_range(255));
        p.det_height   = 15'($urandom_range(255));
        if (shape < 10)
        begin
            p = box_pair_t'({$urandom, $urandom, $urandom, $urandom});
        end
        else if (shape < 20)
        begin
            // degenerate boxes: one dimension of each is zero, unless det_width is then set past track_width
            if ($urandom_range(1)) p.track_width = '0; else p.track_height = '0;
            if ($urandom_range(1)) p.det_width = '0; else p.det_height = '0;
            if ($urandom_range(3) == 0) p.det_width = p.track_width + 15'd1;
        end
        else if (shape < 35)
        begin
            if ($urandom_range(3) == 0)
            begin
                p.track_width  = 15'($urandom);
                p.track_height = 15'($urandom);
            end
            p.det_left   = p.track_left;
            p.det_top    = p.track_top;
            p.det_width  = p.track_width;
            p.det_height = p.track_height;
        end
        else if (shape < 45)
        begin
            p.track_left   = corner_coord();
            p.track_top    = corner_coord();
            p.det_left     = corner_coord();
            p.det_top      = corner_coord();
            p.track_width  = 15'd32767 - 15'($urandom_range(3));
            p.track_height = 15'($urandom);
            p.det_width    = 15'($urandom);
            p.det_height   = 15'd32767 - 15'($urandom_range(3));
        end
        return p;
    endfunction

    task automatic offer_pair(input box_pair_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid   <= 1'b1;
        track_left   <= p.track_left;
        track_top    <= p.track_top;
        track_width  <= p.track_width;
        track_height <= p.track_height;
        track_stale  <= p.track_stale;
        det_left     <= p.det_left;
        det_top      <= p.det_top;
        det_width    <= p.det_width;
        det_height   <= p.det_height;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic drain_costs();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_stale_cost(input logic [COST_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        queue_pair(mk_pair(10, 20, 10, 10, 0, 10, 20, 10, 10));
        queue_pair(mk_pair(0, 0, 10, 10, 0, 50, 0, 10, 10));
        queue_pair(mk_pair(0, 0, 10, 10, 0, 10, 0, 10, 10));
        queue_pair(mk_pair(5, 5, 0, 0, 0, 5, 5, 0, 0));
        queue_pair(mk_pair(0, 0, 20, 20, 0, 5, 5, 0, 7));
        queue_pair(mk_pair(0, 0, 100, 100, 0, 10, 10, 20, 30));
        queue_pair(mk_pair(0, 0, 10, 10, 1, 2, 2, 10, 10));
        queue_pair(mk_pair(3, 3, 0, 0, 1, 3, 3, 0, 0));
        queue_pair(mk_pair(-32768, -32768, 32767, 32767, 0,
                           32767, 32767, 32767, 32767));
        queue_pair(mk_pair(-32768, -32768, 32767, 32767, 0,
                           -32768, -32768, 32767, 32767));
        queue_pair(mk_pair(-32768, -32768, 32767, 32767, 0,
                           -16384, -16384, 32767, 32767));
        queue_pair(mk_pair(32767, 32767, 32767, 32767, 0,
                           32767, 32767, 32767, 32767));
        queue_pair(mk_pair(0, 0, 2, 1, 0, 1, 0, 2, 1));
        queue_pair(mk_pair(0, 0, 0, 10, 0, 0, 0, 10, 10));
        queue_pair(mk_pair(-50, -40, 30, 30, 0, -35, -25, 30, 30));
        queue_pair(mk_pair(0, 0, 32767, 32767, 0, 100, 100, 1, 1));
        queue_pair(mk_pair(0, 0, 32767, 32767, 0, 1, 0, 32767, 32767));
        queue_pair(mk_pair(-1, -1, 32767, 32767, 1, -1, -1, 32767, 32767));
        queue_pair(mk_pair(-1, -1, 32767, 32767, 0, -1, -1, 32767, 32767));
        queue_pair(mk_pair(0, 0, 10, 0, 0, 0, 0, 10, 0));
        queue_pair(mk_pair(32760, -32768, 7, 5, 0, 32765, -32766, 5, 5));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 11;
        recv_idle_pct = 86;
        foreach (directed_pairs[i])
            offer_pair(directed_pairs[i]);
        drain_costs();
        write_stale_cost('0);
        repeat (RANDOM_RUN) offer_pair(random_pair());

        drain_costs();
        send_idle_pct = 86;
        recv_idle_pct = 11;
        write_stale_cost(COST_BITS'($urandom));
        repeat (RANDOM_RUN) offer_pair(random_pair());

        drain_costs();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_stale_cost(COST_MAX);
        hold_req = hold_req + 1;
        repeat (RANDOM_RUN) offer_pair(random_pair());

        drain_costs();
        write_stale_cost(COST_BITS'($urandom));
        repeat (30) offer_pair(random_pair());

        drain_costs();
        repeat (FRAC_BITS + 8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[iou_gated_box_cost_core] OK");
        else
            $display("[iou_gated_box_cost_core] ERROR");
        $finish;
    end

endmodule
